// ===== hdl/utf8_text_sanitizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer assertion macros
// Shared property forms for the sanitizer checkers.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_SANITIZER_CORE_DEFINES_SVH
`define UTF8_TEXT_SANITIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define UTSAN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define UTSAN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utsan_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer package
// Types, constants and code point classifiers shared by the sanitizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utsan_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_INVISIBLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE_SPACE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_PUNCT       = 2'd2;

  // At most five output bytes per input byte: a space plus a four-byte character.
  localparam int OUT_MAX = 5;
  localparam int CNT_W   = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CP_W = 21;

  // Fold stage codes; any other value is the ASCII replacement byte.
  localparam logic [7:0] FOLD_KEEP     = 8'h00;
  localparam logic [7:0] FOLD_ELLIPSIS = 8'h01;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_APOS  = 8'h27;
  localparam logic [7:0] ASCII_QUOTE = 8'h22;
  localparam logic [7:0] ASCII_DASH  = 8'h2D;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // One queue entry: the bytes one input beat produces.
  typedef struct packed {
    logic [OUT_MAX-1:0][7:0] data;
    logic [CNT_W-1:0]        cnt;
    logic                    eot;
  } job_t;

  // Queue status toward the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Controls other than tab/LF/CR, DEL, C1, soft hyphen, zero-width, bidi, BOM.
  function automatic logic is_strippable(input logic [CP_W-1:0] cp);
    logic r;
    r = 1'b0;
    if (cp < 21'h20) r = (cp != 21'h09) && (cp != 21'h0A) && (cp != 21'h0D);
    else if (cp >= 21'h7F && cp <= 21'h9F) r = 1'b1;
    else r = (cp == 21'hAD) || (cp >= 21'h200B && cp <= 21'h200F) ||
             (cp >= 21'h202A && cp <= 21'h202E) ||
             (cp >= 21'h2060 && cp <= 21'h2064) || (cp == 21'hFEFF);
    return r;
  endfunction

  // ASCII whitespace and the Unicode space characters.
  function automatic logic is_space(input logic [CP_W-1:0] cp);
    return (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D) ||
           (cp == 21'hA0) || (cp == 21'h85) || (cp == 21'h1680) ||
           (cp >= 21'h2000 && cp <= 21'h200A) || (cp == 21'h2028) ||
           (cp == 21'h2029) || (cp == 21'h202F) || (cp == 21'h205F) ||
           (cp == 21'h3000);
  endfunction

  // Typographic punctuation to ASCII.
  function automatic logic [7:0] fold_code(input logic [CP_W-1:0] cp);
    logic [7:0] r;
    case (cp)
      21'h2018, 21'h2019, 21'h2032, 21'h2039, 21'h203A: r = ASCII_APOS;
      21'h201C, 21'h201D, 21'h2033, 21'h00AB, 21'h00BB: r = ASCII_QUOTE;
      21'h2012, 21'h2013, 21'h2014, 21'h2015:           r = ASCII_DASH;
      21'h2026:                                         r = FOLD_ELLIPSIS;
      default:                                          r = FOLD_KEEP;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/utf8_text_sanitizer_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer core
// Cleans a UTF-8 byte stream: strips invisible code points, collapses and
// trims whitespace, and folds typographic punctuation to ASCII.
// Input channel: one raw byte per beat (in_byte, end_of_text) on in_valid /
// in_stall. Output channel: one result per beat (out_byte, byte_valid,
// run_last, text_done) on out_valid / out_stall. An input beat gives zero to
// five results; the last one carries run_last, and on the final byte of a
// string also text_done. A string whose final byte yields nothing closes with
// one result with byte_valid low.
// An input beat's first result is offered, when the output side is free, once
// its job has passed the queue and the back end's job register. Throughput:
// one input byte per cycle while each byte yields at most one result and the
// receiver does not stall; the back end sends one result per cycle unless
// stalled, and the job queue (QUEUE_DEPTH entries) lets the input run on.
// Reset empties the queue, restores the register defaults (invisibles and
// whitespace on, fold off) and starts a fresh string. When the receiver
// stalls, the current result holds; once the queue fills, in_stall rises.
// Configuration writes take effect on the next input byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_text_sanitizer_core #(
  parameter int QUEUE_DEPTH = utsan_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [utsan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                            cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            byte_valid,
  output logic                            run_last,
  output logic                            text_done
);
  import utsan_pkg::*;

  logic    push, pop;
  job_t    push_job, head;
  q_stat_t q_status;

  // Decoder and cleaning stages.
  utsan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue.
  utsan_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // Output sequencer.
  utsan_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .run_last  (run_last),
    .text_done (text_done)
  );

endmodule

// ===== hdl/utsan_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer front end
// Holds the configuration, reassembles UTF-8 sequences, applies the three
// cleaning stages and writes each beat's output bytes into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utsan_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [utsan_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                             cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_text,
  input  utsan_pkg::q_stat_t               q_status,
  output logic                             push,
  output utsan_pkg::job_t                  push_job
);
  import utsan_pkg::*;

  logic strip_en, collapse_en, fold_en;

  logic [23:0] partial_sequence, partial_sequence_next;
  logic [1:0]  bytes_expected, bytes_expected_next;
  logic [1:0]  bytes_held, bytes_held_next;
  logic        space_pending, space_pending_next;
  logic        at_text_start, at_text_start_next;

  logic accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_en    <= 1'b1;
      collapse_en <= 1'b1;
      fold_en     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STRIP_INVISIBLES: strip_en    <= cfg_data;
        CFG_COLLAPSE_SPACE:   collapse_en <= cfg_data;
        CFG_FOLD_PUNCT:       fold_en     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode, classify and build the output bytes of the current beat.
  always_comb begin
    logic [CP_W-1:0]   cp;
    logic [3:0][7:0]   cbytes;
    logic [2:0]        clen;
    logic              char_ok;
    logic              keep;
    logic              lead_sp;
    logic [3:0][7:0]   pay;
    logic [2:0]        plen;
    logic [7:0]        f;
    logic [1:0]        exp_dec;

    partial_sequence_next = partial_sequence;
    bytes_expected_next   = bytes_expected;
    bytes_held_next       = bytes_held;
    space_pending_next    = space_pending;
    at_text_start_next    = at_text_start;
    cp      = '0;
    cbytes  = '0;
    clen    = 3'd0;
    char_ok = 1'b0;
    keep    = 1'b0;
    lead_sp = 1'b0;
    pay     = '0;
    plen    = 3'd0;
    f       = FOLD_KEEP;
    exp_dec = bytes_expected - 2'd1;
    push_job = '0;

    if (!strip_en && !collapse_en && !fold_en) begin
      // Every stage off: the raw byte passes through.
      partial_sequence_next = '0;
      bytes_held_next       = '0;
      bytes_expected_next   = '0;
      pay[0] = in_byte;
      plen   = 3'd1;
    end else begin
      if (bytes_expected != 2'd0 && in_byte[7:6] == 2'b10) begin
        // Continuation byte of an open sequence.
        bytes_expected_next = exp_dec;
        if (exp_dec == 2'd0) begin
          partial_sequence_next = '0;
          bytes_held_next       = '0;
          case (bytes_held)
            2'd1: begin
              cp = {10'd0, partial_sequence[4:0], in_byte[5:0]};
              cbytes = {16'd0, in_byte, partial_sequence[7:0]};
              clen = 3'd2;
              char_ok = 1'b1;
            end
            2'd2: begin
              cp = {5'd0, partial_sequence[11:8], partial_sequence[5:0], in_byte[5:0]};
              cbytes = {8'd0, in_byte, partial_sequence[7:0], partial_sequence[15:8]};
              clen = 3'd3;
              char_ok = (cp >= 21'h800);
            end
            default: begin
              cp = {partial_sequence[18:16], partial_sequence[13:8],
                    partial_sequence[5:0], in_byte[5:0]};
              cbytes = {in_byte, partial_sequence[7:0], partial_sequence[15:8],
                        partial_sequence[23:16]};
              clen = 3'd4;
              char_ok = (cp >= 21'h10000) && (cp <= CP_MAX);
            end
          endcase
        end else begin
          partial_sequence_next = {partial_sequence[15:0], in_byte};
          bytes_held_next       = bytes_held + 2'd1;
        end
      end else begin
        // A fresh byte; anything held is discarded.
        partial_sequence_next = '0;
        bytes_held_next       = '0;
        bytes_expected_next   = '0;
        if (in_byte < 8'h80) begin
          cp = {13'd0, in_byte};
          cbytes = {24'd0, in_byte};
          clen = 3'd1;
          char_ok = 1'b1;
        end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
          bytes_expected_next = 2'd1;
        end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
          bytes_expected_next = 2'd2;
        end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
          bytes_expected_next = 2'd3;
        end
        if (bytes_expected_next != 2'd0) begin
          partial_sequence_next = {16'd0, in_byte};
          bytes_held_next       = 2'd1;
        end
      end

      // Invisibles, whitespace and fold stages on a complete character.
      if (char_ok) begin
        keep = !(strip_en && is_strippable(cp));
        if (keep && collapse_en) begin
          if (is_space(cp)) begin
            space_pending_next = 1'b1;
            keep = 1'b0;
          end else begin
            lead_sp = space_pending && !at_text_start;
            space_pending_next = 1'b0;
            at_text_start_next = 1'b0;
          end
        end
        if (keep) begin
          f = fold_en ? fold_code(cp) : FOLD_KEEP;
          if (f == FOLD_ELLIPSIS) begin
            pay  = {8'd0, ASCII_DOT, ASCII_DOT, ASCII_DOT};
            plen = 3'd3;
          end else if (f != FOLD_KEEP) begin
            pay  = {24'd0, f};
            plen = 3'd1;
          end else begin
            pay  = cbytes;
            plen = clen;
          end
        end
      end
    end

    // End of text closes the string.
    if (end_of_text) begin
      partial_sequence_next = '0;
      bytes_held_next       = '0;
      bytes_expected_next   = '0;
      space_pending_next    = 1'b0;
      at_text_start_next    = 1'b1;
    end

    // Place the optional leading space ahead of the payload.
    if (lead_sp) begin
      push_job.data = {pay, ASCII_SPACE};
      push_job.cnt  = plen + 3'd1;
    end else begin
      push_job.data = {8'd0, pay};
      push_job.cnt  = plen;
    end
    push_job.eot = end_of_text;
  end

  // A beat that yields nothing and closes no string leaves no queue entry.
  assign push = accept && ((push_job.cnt != '0) || end_of_text);

  // Decoder and stage state.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sequence <= '0;
      bytes_expected   <= '0;
      bytes_held       <= '0;
      space_pending    <= 1'b0;
      at_text_start    <= 1'b1;
    end else if (accept) begin
      partial_sequence <= partial_sequence_next;
      bytes_expected   <= bytes_expected_next;
      bytes_held       <= bytes_held_next;
      space_pending    <= space_pending_next;
      at_text_start    <= at_text_start_next;
    end
  end

endmodule

// ===== hdl/utsan_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer job queue
// Short FIFO of output jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utsan_queue #(
  parameter int DEPTH = utsan_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utsan_pkg::job_t    push_job,
  input  logic               pop,
  output utsan_pkg::job_t    head,
  output utsan_pkg::q_stat_t status
);
  import utsan_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/utsan_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer back end
// Takes jobs from the queue and sends their bytes out one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utsan_back (
  input  logic               clk,
  input  logic               rst,
  input  utsan_pkg::job_t    head,
  input  utsan_pkg::q_stat_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               text_done
);
  import utsan_pkg::*;

  job_t             cur;
  logic             active;
  logic [CNT_W-1:0] idx;
  logic             last, beat, load;

  // Current beat of the job in hand.
  assign last       = (cur.cnt == '0) || (idx == cur.cnt - 1'b1);
  assign out_valid  = active;
  assign byte_valid = (cur.cnt != '0);
  assign out_byte   = byte_valid ? cur.data[idx] : 8'd0;
  assign run_last   = last;
  assign text_done  = last && cur.eot;

  assign beat = active && !out_stall;
  assign load = !active || (beat && last);
  assign pop  = load && !q_status.empty;

  // Job register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Beat sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= !q_status.empty;
      idx    <= '0;
    end else if (beat) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== hdl/utsan_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer port checker
// Watches the core's output port for framing and hold rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_text_sanitizer_core_defines.svh"

module utsan_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       run_last,
  input logic       text_done
);

  logic        held_res;
  logic [10:0] res_word;
  logic        empty_res;
  logic        close_ok;

  // Result fields and the conditions the properties test.
  assign held_res  = out_valid && out_stall;
  assign res_word  = {out_byte, byte_valid, run_last, text_done};
  assign empty_res = out_valid && !byte_valid;
  assign close_ok  = run_last && text_done && (out_byte == 8'd0);

  // A stalled result stays put until it is taken.
  `UTSAN_ASSERT_NEXT(a_out_hold, clk, rst, held_res, out_valid && $stable(res_word), "beat moved")

  // A string closes only on the last result of a beat.
  `UTSAN_ASSERT_NOW(a_done_last, clk, rst, out_valid && text_done, run_last, "done before last")

  // An empty result only closes a string.
  `UTSAN_ASSERT_NOW(a_empty_done, clk, rst, empty_res, close_ok, "stray empty result")

  // A beat with more results to come carries a real byte.
  `UTSAN_ASSERT_NOW(a_mid_byte, clk, rst, out_valid && !run_last, byte_valid, "empty mid burst")

endmodule

bind utf8_text_sanitizer_core utsan_checker u_utsan_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .byte_valid(byte_valid),
  .run_last  (run_last),
  .text_done (text_done)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text sanitizer core testbench
// Feeds byte streams of valid, broken and typographic UTF-8 text through the
// core under every combination of the three stage enables. A local model of
// the decoder and the three stages predicts each result beat, and the monitor
// compares every output beat field by field. Both channels idle and stall at
// random, and one long receiver hold-off fills the core's queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import utsan_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_BYTES    = 48;

  // One raw input beat and one cleaned output beat.
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } raw_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
  } clean_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = 8'h00;
  logic                 end_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 byte_valid;
  logic                 run_last;
  logic                 text_done;

  utf8_text_sanitizer_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_done  (text_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus and expectation stores.
  raw_beat_t   raw_bytes_q[$];
  clean_beat_t clean_exp_q[$];
  logic [7:0]  char_bytes[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int phase_bytes = 0;
  int results_seen = 0;
  int texts_closed = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic in_beat = 1'b0;

  // Local copy of the register file and the sanitizer state.
  logic        en_strip = 1'b1;
  logic        en_collapse = 1'b1;
  logic        en_fold = 1'b0;
  logic [23:0] seq_bytes = '0;
  logic [1:0]  seq_due = '0;
  logic [1:0]  seq_held = '0;
  logic        gap_pending = 1'b0;
  logic        text_start = 1'b1;

  // Code points removed by the invisibles stage.
  function automatic logic is_hidden(input logic [CP_W-1:0] cp);
    if (cp < 21'h20) return !(cp == 21'h09 || cp == 21'h0A || cp == 21'h0D);
    if (cp >= 21'h7F && cp <= 21'h9F) return 1'b1;
    return cp == 21'hAD || (cp >= 21'h200B && cp <= 21'h200F) ||
           (cp >= 21'h202A && cp <= 21'h202E) ||
           (cp >= 21'h2060 && cp <= 21'h2064) || cp == 21'hFEFF;
  endfunction

  // Code points that the whitespace stage merges into one space.
  function automatic logic is_blank(input logic [CP_W-1:0] cp);
    if (cp == 21'h20 || (cp >= 21'h09 && cp <= 21'h0D)) return 1'b1;
    return cp == 21'hA0 || cp == 21'h85 || cp == 21'h1680 ||
           (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
           cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F || cp == 21'h3000;
  endfunction

  // ASCII replacement for typographic punctuation.
  function automatic logic [7:0] ascii_of(input logic [CP_W-1:0] cp);
    logic [7:0] r;
    r = FOLD_KEEP;
    if (cp == 21'h2018 || cp == 21'h2019 || cp == 21'h2032 || cp == 21'h2039 ||
        cp == 21'h203A) r = ASCII_APOS;
    else if (cp == 21'h201C || cp == 21'h201D || cp == 21'h2033 || cp == 21'hAB ||
             cp == 21'hBB) r = ASCII_QUOTE;
    else if (cp >= 21'h2012 && cp <= 21'h2015) r = ASCII_DASH;
    else if (cp == 21'h2026) r = FOLD_ELLIPSIS;
    return r;
  endfunction

  // Runs one complete character through the three stages.
  function automatic void clean_char(input logic [CP_W-1:0] cp,
                                     input logic [3:0][7:0] raw, input int nraw);
    logic [7:0] f;
    int k;
    if (en_strip && is_hidden(cp)) return;
    if (en_collapse) begin
      if (is_blank(cp)) begin
        gap_pending = 1'b1;
        return;
      end
      if (gap_pending && !text_start) char_bytes.push_back(ASCII_SPACE);
      gap_pending = 1'b0;
      text_start = 1'b0;
    end
    f = en_fold ? ascii_of(cp) : FOLD_KEEP;
    if (f == FOLD_ELLIPSIS) begin
      repeat (3) char_bytes.push_back(ASCII_DOT);
      return;
    end
    if (f != FOLD_KEEP) begin
      char_bytes.push_back(f);
      return;
    end
    for (k = 0; k < nraw; k++) char_bytes.push_back(raw[k]);
  endfunction

  // UTF-8 reassembly; malformed sequences vanish without output.
  function automatic void decode_utf8(input logic [7:0] b);
    logic [3:0][7:0] raw;
    logic [CP_W-1:0] cp;
    logic ok;
    int n;
    raw = '0;
    if (seq_due != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_due--;
        if (seq_due == 2'd0) begin
          n = seq_held + 1;
          ok = 1'b1;
          if (n == 2) begin
            raw[0] = seq_bytes[7:0];
            cp = {10'b0, raw[0][4:0], b[5:0]};
          end else if (n == 3) begin
            raw[0] = seq_bytes[15:8];
            raw[1] = seq_bytes[7:0];
            cp = {5'b0, raw[0][3:0], raw[1][5:0], b[5:0]};
            ok = cp >= 21'h800;
          end else begin
            n = 4;
            raw[0] = seq_bytes[23:16];
            raw[1] = seq_bytes[15:8];
            raw[2] = seq_bytes[7:0];
            cp = {raw[0][2:0], raw[1][5:0], raw[2][5:0], b[5:0]};
            ok = cp >= 21'h10000 && cp <= CP_MAX;
          end
          raw[n-1] = b;
          seq_bytes = '0;
          seq_held = '0;
          if (ok) clean_char(cp, raw, n);
          return;
        end
        seq_bytes = {seq_bytes[15:0], b};
        seq_held++;
        return;
      end
      // A fresh byte breaks the open sequence.
      seq_bytes = '0;
      seq_held = '0;
      seq_due = '0;
    end
    if (b < 8'h80) begin
      raw[0] = b;
      clean_char({13'b0, b}, raw, 1);
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) seq_due = 2'd1;
    else if (b >= 8'hE0 && b <= 8'hEF) seq_due = 2'd2;
    else if (b >= 8'hF0 && b <= 8'hF4) seq_due = 2'd3;
    else return;
    seq_bytes = {16'b0, b};
    seq_held = 2'd1;
  endfunction

  // Predicts the result beats of one accepted input byte.
  function automatic void sanitize_byte(input logic [7:0] b, input logic eot);
    clean_beat_t r;
    int k;
    int n;
    char_bytes.delete();
    if (!en_strip && !en_collapse && !en_fold) begin
      seq_bytes = '0;
      seq_held = '0;
      seq_due = '0;
      char_bytes.push_back(b);
    end else begin
      decode_utf8(b);
    end
    if (eot) begin
      seq_bytes = '0;
      seq_held = '0;
      seq_due = '0;
      gap_pending = 1'b0;
      text_start = 1'b1;
    end
    n = (char_bytes.size() > OUT_MAX) ? OUT_MAX : char_bytes.size();
    for (k = 0; k < n; k++) begin
      r.data = char_bytes[k];
      r.valid = 1'b1;
      r.last = (k == n - 1);
      r.done = (k == n - 1) && eot;
      clean_exp_q.push_back(r);
    end
    if (n == 0 && eot) clean_exp_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
  endfunction

  // Monitor: checks output beats, predicts from input beats, and watches for hangs.
  always @(posedge clk) begin
    clean_beat_t want;
    in_beat = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (clean_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h valid %b last %b done %b",
                     out_byte, byte_valid, run_last, text_done);
        end else begin
          want = clean_exp_q.pop_front();
          if (out_byte !== want.data || byte_valid !== want.valid ||
              run_last !== want.last || text_done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                       results_seen, want.data, want.valid, want.last, want.done,
                       out_byte, byte_valid, run_last, text_done);
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_beat = 1'b1;
        bytes_taken++;
        if (end_of_text) texts_closed++;
        sanitize_byte(in_byte, end_of_text);
      end
      if (in_beat || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat for %0d cycles, %0d results still due",
                 idle_cycles, clean_exp_q.size());
        $display("[utf8_text_sanitizer_core] ERROR");
        $finish;
      end
    end
  end

  // Driver: offers the next queued byte once the current beat has gone.
  always @(negedge clk) begin
    raw_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (raw_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = raw_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= nxt.data;
        end_of_text <= nxt.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eot);
    raw_bytes_q.push_back('{b, eot});
    bytes_queued++;
    phase_bytes++;
  endtask

  // Encodes a code point in a chosen length and queues its first keep bytes.
  task automatic push_cp(input logic [CP_W-1:0] cp, input int len, input int keep);
    logic [3:0][7:0] enc;
    int k;
    enc = '0;
    case (len)
      1: enc[0] = cp[7:0];
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (k = 0; k < keep; k++) push_byte(enc[k], 1'b0);
  endtask

  task automatic push_char(input logic [CP_W-1:0] cp);
    int len;
    len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    push_cp(cp, len, len);
  endtask

  // Queues one random text; the last byte closes it when close is set.
  task automatic push_text(input int nchars, input logic close);
    logic [CP_W-1:0] cp;
    int i;
    int len;
    for (i = 0; i < nchars; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: push_char(CP_W'($urandom_range(8'h21, 8'h7E)));
        6, 7: push_char($urandom_range(1) ? 21'h20 : CP_W'($urandom_range(8'h09, 8'h0D)));
        8: push_char($urandom_range(3) == 0 ? 21'h7F : CP_W'($urandom_range(0, 8'h1F)));
        9: push_char(CP_W'($urandom_range(8'h80, 8'h9F)));
        10: begin
          case ($urandom_range(8))
            0: cp = 21'hA0;
            1: cp = 21'h85;
            2: cp = 21'h1680;
            3: cp = 21'h2028;
            4: cp = 21'h2029;
            5: cp = 21'h202F;
            6: cp = 21'h205F;
            7: cp = 21'h3000;
            default: cp = CP_W'($urandom_range(21'h2000, 21'h200A));
          endcase
          push_char(cp);
        end
        11: begin
          case ($urandom_range(4))
            0: cp = 21'hAD;
            1: cp = CP_W'($urandom_range(21'h200B, 21'h200F));
            2: cp = CP_W'($urandom_range(21'h202A, 21'h202E));
            3: cp = CP_W'($urandom_range(21'h2060, 21'h2064));
            default: cp = 21'hFEFF;
          endcase
          push_char(cp);
        end
        12, 13: begin
          case ($urandom_range(14))
            0: cp = 21'h2018;
            1: cp = 21'h2019;
            2: cp = 21'h2032;
            3: cp = 21'h2039;
            4: cp = 21'h203A;
            5: cp = 21'h201C;
            6: cp = 21'h201D;
            7: cp = 21'h2033;
            8: cp = 21'hAB;
            9: cp = 21'hBB;
            10, 11: cp = 21'h2026;
            default: cp = CP_W'($urandom_range(21'h2012, 21'h2015));
          endcase
          push_char(cp);
        end
        14: push_char(CP_W'($urandom_range(21'h80, 21'h7FF)));
        15: push_char(CP_W'($urandom_range(1) ? $urandom_range(21'hD800, 21'hDFFF)
                                              : $urandom_range(21'h800, 21'hFFFF)));
        16: push_char(CP_W'($urandom_range(21'h10000, CP_MAX)));
        17: begin
          // Overlong forms and code points past the Unicode range.
          case ($urandom_range(3))
            0: push_cp(CP_W'($urandom_range(0, 21'h7F)), 2, 2);
            1: push_cp(CP_W'($urandom_range(0, 21'h7FF)), 3, 3);
            2: push_cp(CP_W'($urandom_range(0, 21'hFFFF)), 4, 4);
            default: push_cp(CP_W'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
          endcase
        end
        18: begin
          // A sequence cut short by whatever follows.
          len = $urandom_range(2, 4);
          cp = CP_W'((len == 2) ? $urandom_range(21'h80, 21'h7FF) :
                     (len == 3) ? $urandom_range(21'h800, 21'hFFFF) :
                                  $urandom_range(21'h10000, CP_MAX));
          push_cp(cp, len, $urandom_range(1, len - 1));
        end
        default: begin
          case ($urandom_range(2))
            0: push_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            1: push_byte(8'($urandom_range(1) ? $urandom_range(8'hC0, 8'hC1)
                                              : $urandom_range(8'hF5, 8'hFF)), 1'b0);
            default: push_byte(8'($urandom_range(8'hFF)), 1'b0);
          endcase
        end
      endcase
    end
    if (close && raw_bytes_q.size() != 0) raw_bytes_q[$].eot = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_STRIP_INVISIBLES: en_strip = val;
      CFG_COLLAPSE_SPACE:   en_collapse = val;
      default:              en_fold = val;
    endcase
  endtask

  task automatic set_stages(input logic [2:0] en);
    write_reg(CFG_STRIP_INVISIBLES, en[2]);
    write_reg(CFG_COLLAPSE_SPACE, en[1]);
    write_reg(CFG_FOLD_PUNCT, en[0]);
  endtask

  // Waits until every byte has been taken and every result has come back.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || clean_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [2:0] stage_set [8];
    int p;
    stage_set = '{3'b111, 3'b110, 3'b000, 3'b001, 3'b100, 3'b010, 3'b011, 3'b101};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text with every stage on: trimming, stripping, a five-byte
    // burst, the ellipsis, broken and stray bytes, and a blank final byte.
    set_stages(3'b111);
    @(posedge clk);
    push_byte(8'h20, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_char(21'h200B);
    push_char(21'h1F600);
    push_char(21'h2026);
    push_cp(21'h110000, 4, 4);
    push_byte(8'hC1, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_cp(21'h2014, 3, 2);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h09, 1'b1);
    wait_drained();

    // Random phases over every enable combination and every idling pattern.
    for (p = 0; p < 8; p++) begin
      set_stages(stage_set[p]);
      @(posedge clk);
      send_idle_pct = (p % 4 == 1) ? 68 : (p % 4 == 3) ? 8 : 0;
      recv_stall_pct = (p % 4 == 2) ? 68 : (p % 4 == 3) ? 8 : 0;
      if (p == 4) hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) push_text($urandom_range(1, 12), 1'b1);
      // Sometimes leave a string open so the next setting applies mid-text.
      if ($urandom_range(1)) push_text($urandom_range(1, 3), 1'b0);
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (clean_exp_q.size() != 0) mismatches += clean_exp_q.size();
    $display("checked %0d result beats from %0d input bytes (%0d closed strings)",
             results_seen, bytes_taken, texts_closed);
    $display("all eight enable settings, four idling patterns and one long output hold-off");
    if (mismatches == 0) begin
      $display("[utf8_text_sanitizer_core] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[utf8_text_sanitizer_core] ERROR");
    end
    $finish;
  end

endmodule
